// ----- rtl/ipfc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipfc_pkg: shared types and constants
// Item and command formats for the flow statistics table.
// ----------------------------------------------------------------------------
package ipfc_pkg;

  localparam int FLOW_ENTRIES_DEF = 32;
  localparam logic [15:0] ETH_HDR_BYTES = 16'd14;

  localparam logic [1:0] ST_RECORD = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_DROP   = 2'd2;

  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_DUMP  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] len;
    logic [31:0] sec;
    logic [19:0] usec;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] src;
    logic [31:0] dst;
    logic [47:0] bytes;
    logic [31:0] pkts;
    logic [31:0] sec;
    logic [19:0] usec;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/ipfc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipfc_queue: two-entry item queue
// Decouples the input stage from the table engine.
// ----------------------------------------------------------------------------
module ipfc_queue import ipfc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output item_t      out_item
);

  item_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_item  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ipfc_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipfc_engine: flow table engine
// Parallel key match in flip-flops, counter read-modify-write in memory,
// dump drain that reads each entry once the previous one has been sent.
// ----------------------------------------------------------------------------
module ipfc_engine import ipfc_pkg::*; #(
  parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       res_valid,
  input  wire logic  res_ready,
  output result_t    res
);

  localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CW = $clog2(FLOW_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(FLOW_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MATCH = 5'b00010,
    S_READ  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DUMP  = 5'b10000
  } state_t;

  state_t          state;
  item_t           cur;
  logic [CW-1:0]   count;
  logic [31:0]     key_src [FLOW_ENTRIES];
  logic [31:0]     key_dst [FLOW_ENTRIES];
  logic [47:0]     bytes_mem [FLOW_ENTRIES];
  logic [31:0]     pkts_mem [FLOW_ENTRIES];
  logic [31:0]     sec_mem [FLOW_ENTRIES];
  logic [19:0]     usec_mem [FLOW_ENTRIES];
  logic [47:0]     rd_bytes;
  logic [31:0]     rd_pkts;
  logic [31:0]     rd_sec;
  logic [19:0]     rd_usec;
  logic [31:0]     rd_src;
  logic [31:0]     rd_dst;
  logic [IW-1:0]   idx;
  logic [IW-1:0]   hit_idx;
  logic            hit_any;
  logic            hit;
  logic [CW-1:0]   dptr;
  logic            rd_pending;
  logic [47:0]     frame;
  logic [48:0]     sum;
  logic            res_free;

  assign frame    = 48'(cur.len) + 48'(ETH_HDR_BYTES);
  assign sum      = {1'b0, rd_bytes} + {1'b0, frame};
  assign in_ready = (state == S_IDLE);
  assign res_free = !res_valid || res_ready;

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      if (CW'(i) < count && key_src[i] == cur.src && key_dst[i] == cur.dst &&
          !hit_any) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    // memory read port, registered
    rd_bytes <= bytes_mem[idx];
    rd_pkts  <= pkts_mem[idx];
    rd_sec   <= sec_mem[idx];
    rd_usec  <= usec_mem[idx];
    rd_src   <= key_src[idx];
    rd_dst   <= key_dst[idx];
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      res_valid  <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur   <= in_item;
            state <= (in_item.func == FUNC_DUMP) ? S_DUMP : S_MATCH;
            dptr  <= '0;
            idx   <= '0;
            rd_pending <= 1'b0;
          end
        end
        S_MATCH: begin
          if (hit_any) begin
            idx   <= hit_idx;
            hit   <= 1'b1;
            state <= S_READ;
          end else if (count == FULL) begin
            if (res_free) begin
              res <= '{ST_DROP, cur.src, cur.dst, frame, 32'd1, cur.sec,
                       cur.usec, 1'b1};
              res_valid <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            idx <= count[IW-1:0];
            key_src[count[IW-1:0]] <= cur.src;
            key_dst[count[IW-1:0]] <= cur.dst;
            hit   <= 1'b0;
            state <= S_WRITE;
          end
        end
        S_READ: state <= S_WRITE;
        S_WRITE: begin
          bytes_mem[idx] <= hit ? (sum[48] ? {48{1'b1}} : sum[47:0]) : frame;
          pkts_mem[idx]  <= hit ? ((&rd_pkts) ? rd_pkts : rd_pkts + 32'd1)
                                : 32'd1;
          sec_mem[idx]   <= cur.sec;
          usec_mem[idx]  <= cur.usec;
          if (!hit) count <= count + CW'(1);
          state <= S_IDLE;
        end
        S_DUMP: begin
          if (count == '0) begin
            if (res_free) begin
              res <= '{ST_EMPTY, 32'd0, 32'd0, 48'd0, 32'd0, 32'd0, 20'd0, 1'b1};
              res_valid <= 1'b1;
              state <= S_IDLE;
            end
          end else if (!rd_pending) begin
            // issue read of the next entry
            idx <= dptr[IW-1:0];
            rd_pending <= 1'b1;
          end else if (res_free) begin
            res <= '{ST_RECORD, rd_src, rd_dst, rd_bytes, rd_pkts, rd_sec,
                     rd_usec, (dptr + CW'(1) == count)};
            res_valid  <= 1'b1;
            rd_pending <= 1'b0;
            if (dptr + CW'(1) == count) begin
              count <= '0;
              state <= S_IDLE;
            end else begin
              // point the read port at the next entry ahead of its read
              idx  <= IW'(dptr + CW'(1));
              dptr <= dptr + CW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ip_flow_byte_packet_counter_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ip_flow_byte_packet_counter_core: per-flow IPv4 byte and packet counter
// Front queue takes requests; the table engine matches, updates and dumps.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  s_axis   in   tuser: func; tdata: src_addr, dst_addr, ip_total_len,
//                stamp_sec, stamp_usec
//  m_axis   out  tuser: status; tdata: flow_src, flow_dst, byte_total,
//                packet_total, seen_sec, seen_usec; tlast: last
// A packet request holds the engine for accept, match, memory read and write on
// a hit, skips the memory read on an insert and ends after the match on a drop;
// a dump reads each entry in turn through the single memory read port.
// Synchronous reset empties the table at once.
// The output register lets the queue keep accepting while a result stalls.
module ip_flow_byte_packet_counter_core import ipfc_pkg::*; #(
  parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // src_addr, dst_addr, ip_total_len, stamp_sec, stamp_usec, pad
  input  wire logic [135:0] s_axis_tdata,
  // func
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // flow_src, flow_dst, byte_total, packet_total, seen_sec, seen_usec, pad
  output logic [199:0]      m_axis_tdata,
  // status
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  result_t res;

  assign in_item.func = s_axis_tuser;
  assign in_item.src  = s_axis_tdata[31:0];
  assign in_item.dst  = s_axis_tdata[63:32];
  assign in_item.len  = s_axis_tdata[79:64];
  assign in_item.sec  = s_axis_tdata[111:80];
  assign in_item.usec = s_axis_tdata[131:112];

  ipfc_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  ipfc_engine #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_engine (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {4'b0000, res.usec, res.sec, res.pkts, res.bytes,
                         res.dst, res.src};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed under stall");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("bad status code");
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_RECORD |-> m_axis_tlast)
    else $error("marker or drop without last");
`endif

endmodule

`default_nettype wire
